// ----- hdl/hrp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types, character constants and byte class helpers for the
// http request header parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrp_pkg;

  // grammar position
  typedef enum logic [4:0] {
    ST_METHOD_START = 5'd0,
    ST_METHOD       = 5'd1,
    ST_URI          = 5'd2,
    ST_VER_H        = 5'd3,
    ST_VER_T1       = 5'd4,
    ST_VER_T2       = 5'd5,
    ST_VER_P        = 5'd6,
    ST_VER_SLASH    = 5'd7,
    ST_MAJOR_START  = 5'd8,
    ST_MAJOR        = 5'd9,
    ST_MINOR_START  = 5'd10,
    ST_MINOR        = 5'd11,
    ST_LF1          = 5'd12,
    ST_LINE_START   = 5'd13,
    ST_LWS          = 5'd14,
    ST_NAME         = 5'd15,
    ST_SPACE_VALUE  = 5'd16,
    ST_VALUE        = 5'd17,
    ST_LF2          = 5'd18,
    ST_LF3          = 5'd19
  } hrp_state_e;

  typedef enum logic [1:0] {
    STAT_MORE = 2'd0,
    STAT_DONE = 2'd1,
    STAT_BAD  = 2'd2
  } hrp_status_e;

  typedef enum logic [2:0] {
    CAP_NONE    = 3'd0,
    CAP_METHOD  = 3'd1,
    CAP_URI     = 3'd2,
    CAP_VERSION = 3'd3,
    CAP_NAME    = 3'd4,
    CAP_VALUE   = 3'd5
  } hrp_cap_e;

  // character constants
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPR_H = 8'h48;
  localparam logic [7:0] CH_UPPR_P = 8'h50;
  localparam logic [7:0] CH_UPPR_T = 8'h54;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  // byte classes handed from the classifier to the state machine
  typedef struct packed {
    logic is_ctl;
    logic is_token;
    logic is_digit;
    logic is_lws;
  } hrp_class_t;

  // one result item
  typedef struct packed {
    hrp_status_e status;
    hrp_cap_e    capture_kind;
    logic        new_header;
    logic [7:0]  byte_out;
  } hrp_result_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= CH_CTL_MAX) || (b == CH_DEL);
  endfunction

  function automatic logic is_tspecial(input logic [7:0] b);
    logic r;
    case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
      8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
      8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default:                    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_tspecial(b);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? b + CASE_OFS : b;
  endfunction

endpackage

// ----- hdl/http_request_header_parser.sv -----
// ----------------------------------------------------------------------------
// http_request_header_parser
// path: a request byte accepted into the input register is loaded into the
//   result register once that register frees up, and its result is offered
//   from there (input register, then result register)
// throughput: one byte per cycle unless the result side stalls; the grammar
//   state machine takes one transition per byte, and both stages hold only under back pressure
// reset: rst_ni low clears both stage valids, sets method start and clears
//   the seen-header flag; payload registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,

  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tuser,   // [0] restart

  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] status, [9:2] byte_out, [15:10] zero
  output logic [3:0]  m_axis_tuser    // [2:0] capture_kind, [3] new_header
);

  // ---------------------------------------------------------------------------
  // handshake control
  // the result register frees up when empty or being taken, the input
  // register moves into it whenever it holds a request and the result
  // register frees up; a new request is taken when the input stage is empty or drains
  // ---------------------------------------------------------------------------
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic step;
  logic s_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = in_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // input register: request byte and restart flag
  // ---------------------------------------------------------------------------
  logic [7:0] byte_q;
  logic       restart_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      byte_q    <= s_axis_tdata;
      restart_q <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // byte classes and grammar step
  // ---------------------------------------------------------------------------
  hrp_pkg::hrp_class_t  cls;
  hrp_pkg::hrp_result_t res;

  hrp_classify u_classify (
    .byte_i  (byte_q),
    .class_o (cls)
  );

  // state advances only when the result actually moves to the output stage
  hrp_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (byte_q),
    .restart_i (restart_q),
    .class_i   (cls),
    .result_o  (res)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  hrp_pkg::hrp_result_t res_q;

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q.byte_out, res_q.status};
  assign m_axis_tuser  = {res_q.new_header, res_q.capture_kind};

`ifndef NO_ASSERTIONS
  // a bad byte is never captured
  a_bad_no_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.status == hrp_pkg::STAT_BAD)
      |-> (res_q.capture_kind == hrp_pkg::CAP_NONE))
    else $error("bad byte carries a capture tag");

  // a new header flag only comes with a header name byte
  a_new_header_is_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.new_header)
      |-> (res_q.capture_kind == hrp_pkg::CAP_NAME))
    else $error("new header flag outside header name");

  // uncaptured results carry a zero byte and no header flag
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.capture_kind == hrp_pkg::CAP_NONE)
      |-> (res_q.byte_out == 8'h00 && !res_q.new_header))
    else $error("uncaptured result carries data");

  // the input stage never loses a request while the output is stalled
  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(byte_q) && $stable(restart_q)))
    else $error("pending request lost during stall");
`endif

endmodule

// ----- hdl/hrp_classify.sv -----
// ----------------------------------------------------------------------------
// hrp_classify
// sorts one request byte into the character classes of the grammar
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_classify (
  input  logic [7:0]         byte_i,
  output hrp_pkg::hrp_class_t class_o
);

  always_comb begin
    class_o.is_ctl   = hrp_pkg::is_ctl(byte_i);
    class_o.is_token = hrp_pkg::is_token(byte_i);
    class_o.is_digit = hrp_pkg::is_digit(byte_i);
    class_o.is_lws   = (byte_i == hrp_pkg::CH_SP) || (byte_i == hrp_pkg::CH_HT);
  end

endmodule

// ----- hdl/hrp_fsm.sv -----
// ----------------------------------------------------------------------------
// hrp_fsm
// grammar state machine: one transition and one result per request byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                restart_i,
  input  hrp_pkg::hrp_class_t class_i,
  output hrp_pkg::hrp_result_t result_o
);

  hrp_pkg::hrp_state_e state_q, state_d;
  logic                seen_header_q, seen_header_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= hrp_pkg::ST_METHOD_START;
      seen_header_q <= 1'b0;
    end else if (step_i) begin
      state_q       <= state_d;
      seen_header_q <= seen_header_d;
    end
  end

  hrp_pkg::hrp_status_e st;
  hrp_pkg::hrp_cap_e    cap;
  logic                 nh;

  always_comb begin
    state_d       = state_q;
    seen_header_d = seen_header_q;
    st            = hrp_pkg::STAT_MORE;
    cap           = hrp_pkg::CAP_NONE;
    nh            = 1'b0;

    case (state_q)
      hrp_pkg::ST_METHOD_START: begin
        if (class_i.is_token) begin
          state_d = hrp_pkg::ST_METHOD;
          cap     = hrp_pkg::CAP_METHOD;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_METHOD: begin
        if (byte_i == hrp_pkg::CH_SP) state_d = hrp_pkg::ST_URI;
        else if (class_i.is_token) cap = hrp_pkg::CAP_METHOD;
        else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_URI: begin
        if (byte_i == hrp_pkg::CH_SP) state_d = hrp_pkg::ST_VER_H;
        else if (class_i.is_ctl) st = hrp_pkg::STAT_BAD;
        else cap = hrp_pkg::CAP_URI;
      end
      hrp_pkg::ST_VER_H: begin
        if (byte_i == hrp_pkg::CH_UPPR_H) begin
          state_d = hrp_pkg::ST_VER_T1;
          cap     = hrp_pkg::CAP_VERSION;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_VER_T1: begin
        if (byte_i == hrp_pkg::CH_UPPR_T) begin
          state_d = hrp_pkg::ST_VER_T2;
          cap     = hrp_pkg::CAP_VERSION;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_VER_T2: begin
        if (byte_i == hrp_pkg::CH_UPPR_T) begin
          state_d = hrp_pkg::ST_VER_P;
          cap     = hrp_pkg::CAP_VERSION;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_VER_P: begin
        if (byte_i == hrp_pkg::CH_UPPR_P) begin
          state_d = hrp_pkg::ST_VER_SLASH;
          cap     = hrp_pkg::CAP_VERSION;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_VER_SLASH: begin
        if (byte_i == hrp_pkg::CH_SLASH) begin
          state_d = hrp_pkg::ST_MAJOR_START;
          cap     = hrp_pkg::CAP_VERSION;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_MAJOR_START: begin
        if (class_i.is_digit) begin
          state_d = hrp_pkg::ST_MAJOR;
          cap     = hrp_pkg::CAP_VERSION;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_MAJOR: begin
        if (byte_i == hrp_pkg::CH_DOT) begin
          state_d = hrp_pkg::ST_MINOR_START;
          cap     = hrp_pkg::CAP_VERSION;
        end else if (class_i.is_digit) cap = hrp_pkg::CAP_VERSION;
        else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_MINOR_START: begin
        if (class_i.is_digit) begin
          state_d = hrp_pkg::ST_MINOR;
          cap     = hrp_pkg::CAP_VERSION;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_MINOR: begin
        if (byte_i == hrp_pkg::CH_CR) state_d = hrp_pkg::ST_LF1;
        else if (class_i.is_digit) cap = hrp_pkg::CAP_VERSION;
        else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_LF1: begin
        if (byte_i == hrp_pkg::CH_LF) state_d = hrp_pkg::ST_LINE_START;
        else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_LINE_START: begin
        if (byte_i == hrp_pkg::CH_CR) state_d = hrp_pkg::ST_LF3;
        else if (seen_header_q && class_i.is_lws) state_d = hrp_pkg::ST_LWS;
        else if (class_i.is_token) begin
          state_d       = hrp_pkg::ST_NAME;
          cap           = hrp_pkg::CAP_NAME;
          nh            = 1'b1;
          seen_header_d = 1'b1;
        end else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_LWS: begin
        // skip leading white space of a continuation line
        if (byte_i == hrp_pkg::CH_CR) state_d = hrp_pkg::ST_LF2;
        else if (class_i.is_lws) state_d = hrp_pkg::ST_LWS;
        else if (class_i.is_ctl) st = hrp_pkg::STAT_BAD;
        else begin
          state_d = hrp_pkg::ST_VALUE;
          cap     = hrp_pkg::CAP_VALUE;
        end
      end
      hrp_pkg::ST_NAME: begin
        if (byte_i == hrp_pkg::CH_COLON) state_d = hrp_pkg::ST_SPACE_VALUE;
        else if (class_i.is_token) cap = hrp_pkg::CAP_NAME;
        else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_SPACE_VALUE: begin
        if (byte_i == hrp_pkg::CH_SP) state_d = hrp_pkg::ST_VALUE;
        else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_VALUE: begin
        if (byte_i == hrp_pkg::CH_CR) state_d = hrp_pkg::ST_LF2;
        else if (class_i.is_ctl) st = hrp_pkg::STAT_BAD;
        else cap = hrp_pkg::CAP_VALUE;
      end
      hrp_pkg::ST_LF2: begin
        if (byte_i == hrp_pkg::CH_LF) state_d = hrp_pkg::ST_LINE_START;
        else st = hrp_pkg::STAT_BAD;
      end
      hrp_pkg::ST_LF3: begin
        // final position: every further lf reports done again
        st = (byte_i == hrp_pkg::CH_LF) ? hrp_pkg::STAT_DONE : hrp_pkg::STAT_BAD;
      end
      default: st = hrp_pkg::STAT_BAD;
    endcase

    if (restart_i) begin
      state_d       = hrp_pkg::ST_METHOD_START;
      seen_header_d = 1'b0;
      st            = hrp_pkg::STAT_MORE;
      cap           = hrp_pkg::CAP_NONE;
      nh            = 1'b0;
    end

    result_o.status       = st;
    result_o.capture_kind = cap;
    result_o.new_header   = nh;
    if (cap == hrp_pkg::CAP_NONE) result_o.byte_out = 8'h00;
    else if (cap == hrp_pkg::CAP_NAME) result_o.byte_out = hrp_pkg::to_lower(byte_i);
    else result_o.byte_out = byte_i;
  end

`ifndef NO_ASSERTIONS
  // a bad byte leaves the grammar position untouched
  a_bad_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !restart_i && result_o.status == hrp_pkg::STAT_BAD) |=> $stable(state_q))
    else $error("bad byte changed parse state");

  // restart always lands on method start with the header flag clear
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && restart_i) |=> (state_q == hrp_pkg::ST_METHOD_START && !seen_header_q))
    else $error("restart did not clear parser");

  // continuation white space only reachable once a header was seen
  a_lws_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hrp_pkg::ST_LWS) |-> seen_header_q)
    else $error("continuation state without a prior header");
`endif

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for http_request_header_parser
// drives request bytes through the slave stream, predicts the status, field
// tag, header-start flag and captured byte of every request in a model of
// the grammar kept here, and compares each result in order; directed
// requests cover the edges of the grammar, random well-formed requests with
// noise, restarts and truncation cover the rest under varying idle and stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hrp_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PHASE_ITEMS   = 260;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] byte_in
  logic        s_axis_tuser  = 1'b0;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [1:0] status, [9:2] byte_out, [15:10] zero
  logic [3:0]  m_axis_tuser;           // [2:0] capture_kind, [3] new_header

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // parse results still owed by the block, oldest first
  hrp_result_t pending_results[$];

  // grammar position and header flag as the block should hold them
  hrp_state_e grammar_pos    = ST_METHOD_START;
  logic       header_started = 1'b0;

  http_request_header_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // byte classes of the request grammar
  function automatic logic byte_is_ctl(input logic [7:0] b);
    return (b < CH_SP) || (b == CH_DEL);
  endfunction

  function automatic logic byte_is_sep(input logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", "\t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic byte_is_tok(input logic [7:0] b);
    return !b[7] && !byte_is_ctl(b) && !byte_is_sep(b);
  endfunction

  function automatic logic byte_is_dec(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) ? b + CASE_OFS : b;
  endfunction

  // one grammar step: a bad byte leaves the position where it was
  function automatic hrp_result_t parse_byte(input logic [7:0] b, input logic restart);
    hrp_result_t r;
    hrp_state_e  nxt;
    r.status       = STAT_MORE;
    r.capture_kind = CAP_NONE;
    r.new_header   = 1'b0;
    r.byte_out     = 8'h00;
    if (restart) begin
      grammar_pos    = ST_METHOD_START;
      header_started = 1'b0;
      return r;
    end
    nxt = grammar_pos;
    case (grammar_pos)
      ST_METHOD_START: begin
        if (byte_is_tok(b)) begin
          nxt = ST_METHOD; r.capture_kind = CAP_METHOD;
        end else r.status = STAT_BAD;
      end
      ST_METHOD: begin
        if (b == CH_SP) nxt = ST_URI;
        else if (byte_is_tok(b)) r.capture_kind = CAP_METHOD;
        else r.status = STAT_BAD;
      end
      ST_URI: begin
        if (b == CH_SP) nxt = ST_VER_H;
        else if (byte_is_ctl(b)) r.status = STAT_BAD;
        else r.capture_kind = CAP_URI;
      end
      ST_VER_H: begin
        if (b == CH_UPPR_H) begin
          nxt = ST_VER_T1; r.capture_kind = CAP_VERSION;
        end else r.status = STAT_BAD;
      end
      ST_VER_T1: begin
        if (b == CH_UPPR_T) begin
          nxt = ST_VER_T2; r.capture_kind = CAP_VERSION;
        end else r.status = STAT_BAD;
      end
      ST_VER_T2: begin
        if (b == CH_UPPR_T) begin
          nxt = ST_VER_P; r.capture_kind = CAP_VERSION;
        end else r.status = STAT_BAD;
      end
      ST_VER_P: begin
        if (b == CH_UPPR_P) begin
          nxt = ST_VER_SLASH; r.capture_kind = CAP_VERSION;
        end else r.status = STAT_BAD;
      end
      ST_VER_SLASH: begin
        if (b == CH_SLASH) begin
          nxt = ST_MAJOR_START; r.capture_kind = CAP_VERSION;
        end else r.status = STAT_BAD;
      end
      ST_MAJOR_START: begin
        if (byte_is_dec(b)) begin
          nxt = ST_MAJOR; r.capture_kind = CAP_VERSION;
        end else r.status = STAT_BAD;
      end
      ST_MAJOR: begin
        if (b == CH_DOT) begin
          nxt = ST_MINOR_START; r.capture_kind = CAP_VERSION;
        end else if (byte_is_dec(b)) r.capture_kind = CAP_VERSION;
        else r.status = STAT_BAD;
      end
      ST_MINOR_START: begin
        if (byte_is_dec(b)) begin
          nxt = ST_MINOR; r.capture_kind = CAP_VERSION;
        end else r.status = STAT_BAD;
      end
      ST_MINOR: begin
        if (b == CH_CR) nxt = ST_LF1;
        else if (byte_is_dec(b)) r.capture_kind = CAP_VERSION;
        else r.status = STAT_BAD;
      end
      ST_LF1: begin
        if (b == CH_LF) nxt = ST_LINE_START;
        else r.status = STAT_BAD;
      end
      ST_LINE_START: begin
        if (b == CH_CR) nxt = ST_LF3;
        else if (header_started && (b == CH_SP || b == CH_HT)) nxt = ST_LWS;
        else if (byte_is_tok(b)) begin
          nxt            = ST_NAME;
          r.capture_kind = CAP_NAME;
          r.new_header   = 1'b1;
          header_started = 1'b1;
        end else r.status = STAT_BAD;
      end
      ST_LWS: begin
        // folded line: leading blanks are skipped, then the value goes on
        if (b == CH_CR) nxt = ST_LF2;
        else if (b == CH_SP || b == CH_HT) nxt = ST_LWS;
        else if (byte_is_ctl(b)) r.status = STAT_BAD;
        else begin
          nxt = ST_VALUE; r.capture_kind = CAP_VALUE;
        end
      end
      ST_NAME: begin
        if (b == CH_COLON) nxt = ST_SPACE_VALUE;
        else if (byte_is_tok(b)) r.capture_kind = CAP_NAME;
        else r.status = STAT_BAD;
      end
      ST_SPACE_VALUE: begin
        if (b == CH_SP) nxt = ST_VALUE;
        else r.status = STAT_BAD;
      end
      ST_VALUE: begin
        if (b == CH_CR) nxt = ST_LF2;
        else if (byte_is_ctl(b)) r.status = STAT_BAD;
        else r.capture_kind = CAP_VALUE;
      end
      ST_LF2: begin
        if (b == CH_LF) nxt = ST_LINE_START;
        else r.status = STAT_BAD;
      end
      ST_LF3: begin
        // parked here after completion until a restart
        r.status = (b == CH_LF) ? STAT_DONE : STAT_BAD;
      end
      default: r.status = STAT_BAD;
    endcase
    if (r.capture_kind != CAP_NONE)
      r.byte_out = (r.capture_kind == CAP_NAME) ? fold_upper(b) : b;
    grammar_pos = nxt;
    return r;
  endfunction

  function automatic logic [7:0] pick_token();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (!byte_is_tok(b));
    return b;
  endfunction

  // printable or high byte, no blank: fits uri and header values
  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (byte_is_ctl(b) || b == CH_SP);
    return b;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // receiver stalls are drawn anew every cycle
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // result check and handshake watchdog
  always @(posedge clk_i) begin : result_check
    hrp_result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("result with none pending, tdata %h tuser %h",
                                 m_axis_tdata, m_axis_tuser));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[9:2] !== want.byte_out ||
              m_axis_tdata[15:10] !== 6'd0 || m_axis_tuser[2:0] !== want.capture_kind ||
              m_axis_tuser[3] !== want.new_header)
            log_mismatch($sformatf(
              "status %0d/%0d kind %0d/%0d new %0b/%0b byte %h/%h pad %h (exp/got)",
              want.status, m_axis_tdata[1:0], want.capture_kind, m_axis_tuser[2:0],
              want.new_header, m_axis_tuser[3], want.byte_out, m_axis_tdata[9:2],
              m_axis_tdata[15:10]));
        end
      end
    end
  end

  // one request: random idle first, then held until accepted
  task automatic send_item(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = restart;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results = {pending_results, parse_byte(b, restart)};
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // sender holds off until every owed result is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // well-formed requests with random content; some noise bytes, some
  // truncated, some sent without a restart so the completed state is hit
  task automatic run_random_traffic(input int unsigned n_items);
    logic [7:0]  msg[$];
    int unsigned sent;
    int unsigned cut;
    sent = 0;
    while (sent < n_items) begin
      msg.delete();
      repeat ($urandom_range(1, 6)) msg = {msg, pick_token()};
      msg = {msg, CH_SP};
      repeat ($urandom_range(1, 8)) msg = {msg, pick_text()};
      msg = {msg, CH_SP};
      msg = {msg, CH_UPPR_H};
      msg = {msg, CH_UPPR_T};
      msg = {msg, CH_UPPR_T};
      msg = {msg, CH_UPPR_P};
      msg = {msg, CH_SLASH};
      repeat ($urandom_range(1, 2)) msg = {msg, pick_digit()};
      msg = {msg, CH_DOT};
      repeat ($urandom_range(1, 2)) msg = {msg, pick_digit()};
      msg = {msg, CH_CR};
      msg = {msg, CH_LF};
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(1, 6)) msg = {msg, pick_token()};
        msg = {msg, CH_COLON};
        msg = {msg, CH_SP};
        repeat ($urandom_range(0, 6))
          msg = {msg, (($urandom_range(99) < 15) ? CH_SP : pick_text())};
        msg = {msg, CH_CR};
        msg = {msg, CH_LF};
        if ($urandom_range(99) < 30) begin
          // continuation line
          repeat ($urandom_range(1, 2)) msg = {msg, ($urandom_range(1) ? CH_SP : CH_HT)};
          repeat ($urandom_range(0, 4)) msg = {msg, pick_text()};
          msg = {msg, CH_CR};
          msg = {msg, CH_LF};
        end
      end
      msg = {msg, CH_CR};
      msg = {msg, CH_LF};
      if ($urandom_range(99) < 20)
        repeat ($urandom_range(1, 2)) msg = {msg, CH_LF};

      if ($urandom_range(99) < 90) send_item(8'($urandom_range(0, 255)), 1'b1);
      cut = ($urandom_range(99) < 10) ? $urandom_range(0, msg.size() - 1) : msg.size();
      for (int i = 0; i < cut && sent < n_items; i++) begin
        if ($urandom_range(99) < 4) begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
          sent++;
        end
        send_item(msg[i], 1'b0);
        sent++;
      end
    end
  endtask

  // bad first byte retried, high byte in uri, version tags, a header with
  // an uppercase name and empty value
  task automatic test_request_walk();
    send_idle_pct  = 8;
    recv_stall_pct = 65;
    send_item(8'hA5, 1'b1);
    send_item(8'h00, 1'b0);
    send_item("g", 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_SP, 1'b0);
    send_text("HTTP/1.0");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("Z: ");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    drain_results();
  endtask

  // empty line completes, a further lf completes again, anything else is
  // bad until restart
  task automatic test_completion_and_restart();
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    drain_results();
  endtask

  task automatic test_sparse_sender_idle();
    send_idle_pct  = 8;
    recv_stall_pct = 65;
    run_random_traffic(PHASE_ITEMS);
    drain_results();
  endtask

  task automatic test_heavy_sender_idle();
    send_idle_pct  = 65;
    recv_stall_pct = 8;
    run_random_traffic(PHASE_ITEMS);
    drain_results();
  endtask

  task automatic test_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_traffic(PHASE_ITEMS);
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_request_walk();
    test_completion_and_restart();
    test_sparse_sender_idle();
    test_heavy_sender_idle();
    test_full_rate();

    // results trail their requests through the block's registers; leave room for anything stray
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
